[hw/rtl/varint_frame_deframer_defines.svh]
// assertion macros for the varint frame deframer
// expects clk and rst in the scope of each use
`ifndef VARINT_FRAME_DEFRAMER_DEFINES_SVH
`define VARINT_FRAME_DEFRAMER_DEFINES_SVH

// condition holds at every edge out of reset
`define VFD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VFD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define VFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/vfd_pkg.sv]
// shared types and constants for the varint frame deframer
// no dependencies
`timescale 1ns / 1ps

package vfd_pkg;

  localparam int MAX_PAYLOAD = 512;
  localparam int OP_W = 2;
  localparam int KIND_W = 2;
  localparam int LEN_W = 10;
  localparam int ERR_W = 3;
  localparam int CNT_W = 3;
  localparam int TMO_W = 16;
  localparam int ACC_W = 32;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [7:0] PREAMBLE = 8'h00;
  localparam logic [CNT_W-1:0] VARINT_MAX_BYTES = 3'd5;

  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_DROP = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [ERR_W-1:0] ERR_PREAMBLE = 3'd0;
  localparam logic [ERR_W-1:0] ERR_VARINT_LONG = 3'd1;
  localparam logic [ERR_W-1:0] ERR_LEN_LARGE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TIMEOUT = 3'd3;
  localparam logic [ERR_W-1:0] ERR_LINK_LOST = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [7:0]        message_type;
    logic [LEN_W-1:0]  frame_length;
    logic [7:0]        data_out;
    logic              last;
    logic [ERR_W-1:0]  error_code;
  } vfd_result_t;

endpackage

[hw/rtl/vfd_stream_if.sv]
// valid/ready channel interfaces for the deframer input and result items
// depends on vfd_pkg
`timescale 1ns / 1ps

interface vfd_in_if import vfd_pkg::*;;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [7:0]      data_in;

  modport source (output valid, op, data_in, input ready);
  modport sink (input valid, op, data_in, output ready);
endinterface

interface vfd_out_if import vfd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [7:0]        message_type;
  logic [LEN_W-1:0]  frame_length;
  logic [7:0]        data_out;
  logic              last;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, kind, message_type, frame_length, data_out, last,
                  error_code, input ready);
  modport sink (input valid, kind, message_type, frame_length, data_out, last,
                error_code, output ready);
endinterface

[hw/rtl/vfd_core.sv]
// frame parser state machine and result register
// depends on vfd_pkg and varint_frame_deframer_defines.svh
`timescale 1ns / 1ps
`include "varint_frame_deframer_defines.svh"

module vfd_core import vfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [TMO_W-1:0] timeout_ticks,
  input  logic             fire,
  input  logic             take,
  input  logic [OP_W-1:0]  op,
  input  logic [7:0]       data_in,
  output vfd_result_t      res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_TYPE,
    PH_DATA
  } phase_t;

  phase_t           phase, phase_next;
  logic [ACC_W-1:0] varint_acc, varint_acc_next;
  logic [CNT_W-1:0] varint_bytes, varint_bytes_next;
  logic [ACC_W-1:0] length_value, length_value_next;
  logic [7:0]       type_value, type_value_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [TMO_W-1:0] wait_count, wait_count_next;
  vfd_result_t      res_next;

  logic [ACC_W-1:0] acc_part;
  logic [ACC_W-1:0] acc_upd;
  logic [CNT_W-1:0] cnt_inc;
  logic             fin;

  // place the data bits (seven, or four for the fifth group) at the current group position
  always_comb begin
    case (varint_bytes)
      3'd0:    acc_part = {25'b0, data_in[6:0]};
      3'd1:    acc_part = {18'b0, data_in[6:0], 7'b0};
      3'd2:    acc_part = {11'b0, data_in[6:0], 14'b0};
      3'd3:    acc_part = {4'b0, data_in[6:0], 21'b0};
      default: acc_part = {data_in[3:0], 28'b0};
    endcase
  end

  assign acc_upd = varint_acc | acc_part;
  assign cnt_inc = varint_bytes + 3'd1;
  assign fin     = (bytes_left <= LEN_W'(1));

  always_comb begin
    logic             go_idle;
    logic [ERR_W-1:0] err;
    logic             err_hit;

    go_idle           = 1'b0;
    err               = ERR_PREAMBLE;
    err_hit           = 1'b0;
    phase_next        = phase;
    varint_acc_next   = varint_acc;
    varint_bytes_next = varint_bytes;
    length_value_next = length_value;
    type_value_next   = type_value;
    bytes_left_next   = bytes_left;
    wait_count_next   = wait_count;
    res_next          = '0;

    case (op)
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (wait_count >= timeout_ticks) begin
            err_hit = 1'b1;
            err     = ERR_TIMEOUT;
          end else begin
            wait_count_next = wait_count + TMO_W'(1);
          end
        end
      end
      OP_DROP: begin
        if (phase != PH_IDLE) begin
          err_hit = 1'b1;
          err     = ERR_LINK_LOST;
        end
      end
      OP_BYTE: begin
        unique case (phase)
          PH_IDLE: begin
            if (data_in != PREAMBLE) begin
              err_hit = 1'b1;
              err     = ERR_PREAMBLE;
            end else begin
              phase_next        = PH_LEN;
              varint_acc_next   = '0;
              varint_bytes_next = '0;
              wait_count_next   = '0;
            end
          end
          PH_LEN, PH_TYPE: begin
            wait_count_next = '0;
            if (data_in[7]) begin
              if (cnt_inc >= VARINT_MAX_BYTES) begin
                err_hit = 1'b1;
                err     = ERR_VARINT_LONG;
              end else begin
                varint_acc_next   = acc_upd;
                varint_bytes_next = cnt_inc;
              end
            end else if (phase == PH_LEN) begin
              length_value_next = acc_upd;
              varint_acc_next   = '0;
              varint_bytes_next = '0;
              phase_next        = PH_TYPE;
            end else begin
              type_value_next   = acc_upd[7:0];
              varint_acc_next   = '0;
              varint_bytes_next = '0;
              if (length_value > ACC_W'(MAX_PAYLOAD)) begin
                err_hit = 1'b1;
                err     = ERR_LEN_LARGE;
              end else if (length_value == '0) begin
                go_idle               = 1'b1;
                res_next.valid        = 1'b1;
                res_next.kind         = KIND_EMPTY;
                res_next.message_type = acc_upd[7:0];
              end else begin
                bytes_left_next = length_value[LEN_W-1:0];
                phase_next      = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            res_next.valid        = 1'b1;
            res_next.kind         = KIND_PAYLOAD;
            res_next.message_type = type_value;
            res_next.frame_length = length_value[LEN_W-1:0];
            res_next.data_out     = data_in;
            res_next.last         = fin;
            if (fin) begin
              go_idle = 1'b1;
            end else begin
              bytes_left_next = bytes_left - LEN_W'(1);
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase

    if (err_hit) begin
      go_idle             = 1'b1;
      res_next            = '0;
      res_next.valid      = 1'b1;
      res_next.kind       = KIND_ERROR;
      res_next.error_code = err;
    end

    if (go_idle) begin
      phase_next        = PH_IDLE;
      varint_acc_next   = '0;
      varint_bytes_next = '0;
      length_value_next = '0;
      type_value_next   = '0;
      bytes_left_next   = '0;
      wait_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      varint_acc   <= '0;
      varint_bytes <= '0;
      length_value <= '0;
      type_value   <= '0;
      bytes_left   <= '0;
      wait_count   <= '0;
      res.valid    <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      varint_acc   <= varint_acc_next;
      varint_bytes <= varint_bytes_next;
      length_value <= length_value_next;
      type_value   <= type_value_next;
      bytes_left   <= bytes_left_next;
      wait_count   <= wait_count_next;
      res          <= res_next;
    end else if (take) begin
      res.valid <= 1'b0;
    end
  end

  `VFD_ASSERT_ALWAYS(a_varint_count, varint_bytes < VARINT_MAX_BYTES, "varint count overrun")
  `VFD_ASSERT_IMPLY(a_left_clear, phase != PH_DATA, bytes_left == '0, "bytes left outside payload")
  `VFD_ASSERT_IMPLY(a_left_range, phase == PH_DATA,
                    (bytes_left != '0) && (ACC_W'(bytes_left) <= length_value),
                    "bytes left out of range")
  `VFD_ASSERT_IMPLY(a_last_payload, res.valid && res.last, res.kind == KIND_PAYLOAD,
                    "last on non payload item")
  `VFD_ASSERT_NEXT(a_payload_result, fire && (op == OP_BYTE) && (phase == PH_DATA),
                   res.valid, "payload byte without result")

endmodule

[hw/rtl/varint_frame_deframer.sv]
// varint frame deframer top level: input register, parser, config register
// depends on vfd_pkg, vfd_stream_if and vfd_core
`timescale 1ns / 1ps

// Accepts one item per cycle while results are taken: a received byte, a
// timer tick or a link-drop event. Each frame is a zero preamble byte, a
// varint payload length and a varint message type, followed by the payload
// bytes, which come out one per result item tagged with type and length, the
// final one marked last. An empty frame gives one empty-frame item; bad
// preamble, overlong varint, oversize length, timeout and link loss give an
// error item and return to idle. Items pass an input register and the
// parser's single combinational step into the result register; while the
// result register holds an untaken result, the next item waits in the input
// register.
// timeout_ticks sits at APB byte address 0 and resets to 2000; write it only
// while the block is idle.
module varint_frame_deframer import vfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  vfd_in_if.sink      in_ch,
  vfd_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_q_valid;
  logic [OP_W-1:0]  op_q;
  logic [7:0]       data_q;
  logic [TMO_W-1:0] timeout_ticks;
  logic             fire;
  logic             take;
  logic             cfg_hit;
  vfd_result_t      res;

  assign take    = out_ch.valid && out_ch.ready;
  assign fire    = in_q_valid && (!res.valid || take);
  assign in_ch.ready = !in_q_valid || fire;
  assign cfg_hit = (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_q   <= in_ch.op;
      data_q <= in_ch.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      timeout_ticks <= pwdata[TMO_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = cfg_hit ? {16'b0, timeout_ticks} : 32'b0;

  vfd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .fire          (fire),
    .take          (take),
    .op            (op_q),
    .data_in       (data_q),
    .res           (res)
  );

  assign out_ch.valid        = res.valid;
  assign out_ch.kind         = res.kind;
  assign out_ch.message_type = res.message_type;
  assign out_ch.frame_length = res.frame_length;
  assign out_ch.data_out     = res.data_out;
  assign out_ch.last         = res.last;
  assign out_ch.error_code   = res.error_code;

endmodule

[bench/tb.sv]
// testbench for varint_frame_deframer: random and directed link events, self-checking
// depends on vfd_pkg, vfd_stream_if and the deframer top level
`timescale 1ns / 1ps

module tb;
  import vfd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] TIMEOUT_ADDR = 3'd0;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_CAP = 100;
  localparam int LONG_FRAME_BYTES = 20;

  typedef enum logic [1:0] {PH_IDLE, PH_LEN, PH_TYPE, PH_DATA} parse_phase_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [7:0]      data;
  } link_event_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  vfd_in_if  in_ch();
  vfd_out_if out_ch();

  varint_frame_deframer dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  link_event_t pending_items[$];
  vfd_result_t expected_q[$];
  int          queued_events = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;

  // predictor state
  parse_phase_t     parse_ph;
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] acc_bytes;
  logic [ACC_W-1:0] frame_len;
  logic [7:0]       frame_type;
  logic [LEN_W-1:0] bytes_due;
  logic [TMO_W-1:0] ticks_waited;
  logic [TMO_W-1:0] timeout_now;

  function automatic void clear_parser();
    parse_ph = PH_IDLE;
    acc = '0;
    acc_bytes = '0;
    frame_len = '0;
    frame_type = '0;
    bytes_due = '0;
    ticks_waited = '0;
  endfunction

  function automatic vfd_result_t error_item(input logic [ERR_W-1:0] code);
    vfd_result_t r;
    clear_parser();
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic bit deframe_step(input logic [OP_W-1:0] op, input logic [7:0] b,
                                      output vfd_result_t res);
    bit fin;
    res = '0;
    case (op)
      OP_TICK: begin
        if (parse_ph == PH_IDLE) return 0;
        if (ticks_waited >= timeout_now) begin
          res = error_item(ERR_TIMEOUT);
          return 1;
        end
        ticks_waited = ticks_waited + 1'b1;
        return 0;
      end
      OP_DROP: begin
        if (parse_ph == PH_IDLE) return 0;
        res = error_item(ERR_LINK_LOST);
        return 1;
      end
      OP_BYTE: ;
      default: return 0;
    endcase

    case (parse_ph)
      PH_IDLE: begin
        if (b != PREAMBLE) begin
          res = error_item(ERR_PREAMBLE);
          return 1;
        end
        parse_ph = PH_LEN;
        acc = '0;
        acc_bytes = '0;
        ticks_waited = '0;
        return 0;
      end
      PH_LEN, PH_TYPE: begin
        acc = acc | (ACC_W'(b[6:0]) << (7 * acc_bytes));
        acc_bytes = acc_bytes + 1'b1;
        ticks_waited = '0;
        if (b[7]) begin
          if (acc_bytes >= VARINT_MAX_BYTES) begin
            res = error_item(ERR_VARINT_LONG);
            return 1;
          end
          return 0;
        end
        if (parse_ph == PH_LEN) begin
          frame_len = acc;
          acc = '0;
          acc_bytes = '0;
          parse_ph = PH_TYPE;
          return 0;
        end
        frame_type = acc[7:0];
        acc = '0;
        acc_bytes = '0;
        if (frame_len > MAX_PAYLOAD) begin
          res = error_item(ERR_LEN_LARGE);
          return 1;
        end
        if (frame_len == 0) begin
          res.kind = KIND_EMPTY;
          res.message_type = frame_type;
          clear_parser();
          return 1;
        end
        bytes_due = frame_len[LEN_W-1:0];
        parse_ph = PH_DATA;
        return 0;
      end
      default: begin
        fin = (bytes_due <= 1);
        res.kind = KIND_PAYLOAD;
        res.message_type = frame_type;
        res.frame_length = frame_len[LEN_W-1:0];
        res.data_out = b;
        res.last = fin;
        if (fin) clear_parser();
        else bytes_due = bytes_due - 1'b1;
        return 1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s: got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  // input driver
  always @(posedge clk) begin
    link_event_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 31)) begin
        nxt = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op <= nxt.op;
        in_ch.data_in <= nxt.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= !rst && (steady || $urandom_range(0, 99) >= 31);
  end

  // result checking, then prediction for the item accepted at this edge
  always @(posedge clk) begin
    vfd_result_t want, pred;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item, kind", out_ch.kind, -1);
        end else begin
          want = expected_q.pop_front();
          check_field("kind", out_ch.kind, want.kind);
          check_field("message_type", out_ch.message_type, want.message_type);
          check_field("frame_length", out_ch.frame_length, want.frame_length);
          check_field("data_out", out_ch.data_out, want.data_out);
          check_field("last", out_ch.last, want.last);
          check_field("error_code", out_ch.error_code, want.error_code);
        end
      end
      if (in_ch.valid && in_ch.ready && deframe_step(in_ch.op, in_ch.data_in, pred))
        expected_q.push_back(pred);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("varint_frame_deframer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [7:0] data);
    link_event_t ev;
    ev.op = op;
    ev.data = data;
    pending_items.push_back(ev);
    if (op != OP_UNUSED) queued_events++;
  endtask

  // width pads the encoding with continuation bytes, up to five
  task automatic queue_varint(input logic [31:0] v, input int width);
    int n = 1;
    logic [31:0] rest;
    rest = v >> 7;
    while (rest != 0) begin
      n++;
      rest = rest >> 7;
    end
    if (width > n) n = width;
    rest = v;
    for (int i = 0; i < n; i++) begin
      queue_item(OP_BYTE, {1'(i < n - 1), rest[6:0]});
      rest = rest >> 7;
    end
  endtask

  task automatic sprinkle_ticks(input bit on);
    if (on && $urandom_range(0, 11) == 0) queue_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_frame(input int len, input logic [31:0] mtype, input bit ticks);
    queue_item(OP_BYTE, PREAMBLE);
    sprinkle_ticks(ticks);
    queue_varint(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 1);
    sprinkle_ticks(ticks);
    queue_varint(mtype, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 1);
    for (int i = 0; i < len; i++) begin
      sprinkle_ticks(ticks);
      queue_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // waits in a header or payload window, at or just past the limit when it is 20 or less
  task automatic tick_run();
    int k, n;
    queue_item(OP_BYTE, PREAMBLE);
    k = $urandom_range(0, 2);
    if (k > 0) queue_varint(3, 1);
    if (k > 1) begin
      queue_varint($urandom_range(0, 255), 1);
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) queue_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end
    n = (timeout_now <= 20) ? timeout_now + $urandom_range(0, 1) : 3;
    for (int i = 0; i < n; i++) queue_item(OP_TICK, 8'($urandom_range(0, 255)));
    queue_item(OP_DROP, 8'($urandom_range(0, 255)));
  endtask

  task automatic broken_frame();
    int k, n;
    k = $urandom_range(0, 3);
    if (k == 0) begin
      queue_item(OP_BYTE, 8'($urandom_range(1, 255)));
      return;
    end
    queue_item(OP_BYTE, PREAMBLE);
    case (k)
      1: begin
        if ($urandom_range(0, 1)) queue_varint($urandom_range(0, 20), 1);
        for (int i = 0; i < 5; i++) queue_item(OP_BYTE, 8'($urandom_range(128, 255)));
      end
      2: begin
        if ($urandom_range(0, 1)) begin
          queue_varint($urandom_range(MAX_PAYLOAD + 1, 100000), 1);
        end else begin
          for (int i = 0; i < 4; i++) queue_item(OP_BYTE, 8'($urandom_range(128, 255)));
          queue_item(OP_BYTE, 8'($urandom_range(0, 127) | 1));
        end
        queue_varint($urandom, 1);
      end
      default: begin
        queue_varint($urandom_range(1, 6), 1);
        queue_varint($urandom_range(0, 255), 1);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) queue_item(OP_BYTE, 8'($urandom_range(0, 255)));
        queue_item(OP_DROP, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic random_traffic(input int n);
    int stop_at, pick, len;
    stop_at = queued_events + n;
    while (queued_events < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(0, 99);
        len = (len < 10) ? 0 : (len < 90) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        queue_frame(len, $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom, 1'b1);
      end else if (pick < 75) begin
        tick_run();
      end else if (pick < 87) begin
        broken_frame();
      end else begin
        queue_item(OP_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        queue_item(OP_DROP, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic write_timeout(input logic [TMO_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_ADDR;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    timeout_now = v;
    @(negedge clk);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.op = OP_BYTE;
    in_ch.data_in = 8'h00;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = TIMEOUT_ADDR;
    pwdata = 32'h0;
    timeout_now = TIMEOUT_RESET;
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty frame, type 255
    queue_item(OP_BYTE, PREAMBLE);
    queue_varint(0, 1);
    queue_varint(255, 1);
    // one byte frame, type 256 cut to zero
    queue_item(OP_BYTE, PREAMBLE);
    queue_varint(1, 1);
    queue_varint(256, 1);
    queue_item(OP_BYTE, 8'hFF);
    // bad preamble, then events ignored in idle
    queue_item(OP_BYTE, 8'hFF);
    queue_item(OP_TICK, 8'h00);
    queue_item(OP_DROP, 8'h00);
    queue_item(OP_UNUSED, 8'hAA);
    // overlong length varint
    queue_item(OP_BYTE, PREAMBLE);
    for (int i = 0; i < 5; i++) queue_item(OP_BYTE, 8'h80);
    // five byte length with bits past 32, too large after the type
    queue_item(OP_BYTE, PREAMBLE);
    for (int i = 0; i < 4; i++) queue_item(OP_BYTE, 8'hFF);
    queue_item(OP_BYTE, 8'h7F);
    queue_varint(0, 1);
    // link lost in the length varint
    queue_item(OP_BYTE, PREAMBLE);
    queue_item(OP_DROP, 8'h55);
    settle();

    write_timeout(16'd0);
    random_traffic(90);
    settle();
    write_timeout(16'd1);
    random_traffic(90);
    settle();
    write_timeout(TMO_W'($urandom_range(2, 12)));
    random_traffic(110);
    settle();
    write_timeout(16'hFFFF);
    steady = 1'b1;
    // frame at the largest length, cut short by a link drop
    queue_item(OP_BYTE, PREAMBLE);
    queue_varint(32'(MAX_PAYLOAD), 1);
    queue_varint($urandom, 1);
    for (int i = 0; i < LONG_FRAME_BYTES; i++) queue_item(OP_BYTE, 8'($urandom_range(0, 255)));
    queue_item(OP_DROP, 8'($urandom_range(0, 255)));
    random_traffic(90);
    settle();
    steady = 1'b0;
    write_timeout(TMO_W'($urandom_range(13, 20)));
    random_traffic(70);
    settle();

    if (mismatches == 0) begin
      $display("varint_frame_deframer: match");
    end else begin
      $display("varint_frame_deframer: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/vfd_pkg.sv
hw/rtl/vfd_stream_if.sv
hw/rtl/vfd_core.sv
hw/rtl/varint_frame_deframer.sv
bench/tb.sv
